FILE: rtl/core/fsqrt_pkg.sv
// Package for the single precision square root block.
// Holds the shared constants and the per-cell state type; no dependencies.
`timescale 1ns / 1ps
package fsqrt_pkg;
	localparam int unsigned STEPS = 25;
	localparam logic [31:0] Q_ONE      = 32'h1000_0000;
	localparam logic [31:0] FIRST_BIT  = 32'h4000_0000;
	localparam logic [31:0] RND_MASK   = 32'h0000_0033;
	localparam logic [31:0] RND_MATCH  = 32'h0000_0001;
	localparam logic [31:0] NAN_RESET  = 32'h7FC0_0000;
	localparam logic [7:0]  EXP_BIAS   = 8'd127;

	// State carried from one root cell to the next.
	typedef struct packed {
		logic        valid;
		logic        pass;     // special result, skip arithmetic
		logic [31:0] word;     // special result word
		logic [7:0]  exp;      // biased result exponent before carry
		logic [31:0] rem;
		logic [31:0] acc;
		logic [31:0] bitv;
		logic        int_hit;
		logic        frac_seen;
		logic        done;
	} cell_t;
endpackage

FILE: rtl/core/fsqrt_cell.sv
// One step of the restoring bit-wise root.
// Depends on fsqrt_pkg.
`timescale 1ns / 1ps
module fsqrt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  fsqrt_pkg::cell_t din,
	output fsqrt_pkg::cell_t dout
);
	import fsqrt_pkg::*;

	cell_t       nxt;
	logic [31:0] trial;
	logic        ge;

	// Integer or fractional step, frozen once the remainder is zero.
	always_comb begin
		nxt   = din;
		trial = din.acc + din.bitv;
		ge    = din.rem >= trial;
		if (din.valid && !din.pass && !din.done) begin
			if ((din.acc >> 1) >= Q_ONE || !din.int_hit) begin
				if (ge) begin
					nxt.rem     = din.rem - trial;
					nxt.acc     = (din.acc >> 1) + din.bitv;
					nxt.int_hit = 1'b1;
				end else begin
					nxt.acc = din.acc >> 1;
				end
				nxt.bitv = din.bitv >> 2;
			end else begin
				if (ge) begin
					nxt.rem = (din.rem - trial) << 1;
					nxt.acc = din.acc + (din.bitv << 1);
				end else begin
					nxt.rem = din.rem << 1;
				end
				nxt.bitv      = din.bitv >> 1;
				nxt.frac_seen = 1'b1;
			end
			nxt.done = (nxt.rem == 32'd0);
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end
endmodule

FILE: rtl/core/float_square_root_top.sv
// Top level of the single precision square root; uses fsqrt_pkg and fsqrt_cell.
// A row of 25 root cells between an unpack stage and a round/pack stage.
`timescale 1ns / 1ps
// Takes one IEEE single word per accepted operand and returns its square
// root word. Each word passes an unpack register, 25 root cells and a
// rounding register before its valid root. The row is a pipeline with one
// word in each cell, so a new operand can be taken every cycle; the whole
// row advances only when the output register is free or being emptied.
// Zeros pass unchanged and other negative words return nan_word.
module float_square_root_top #(
	parameter int unsigned STEPS = fsqrt_pkg::STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] root,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import fsqrt_pkg::*;

	logic [31:0] nan_word_q;
	logic        adv;
	cell_t       chain [STEPS+1];
	cell_t       head;
	logic [7:0]  fld;
	logic [7:0]  ehalf;
	logic [31:0] mant;
	cell_t       last;
	logic [31:0] acc_f;
	logic [31:0] acc_r;
	logic [31:0] r;
	logic [31:0] res;

	// Configuration register is always writable.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nan_word_q <= NAN_RESET;
		end else if (cfg_valid) begin
			nan_word_q <= cfg_data;
		end
	end

	// The row moves when the output word can be replaced.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Unpack: hidden one, odd exponent adjust, halved exponent.
	always_comb begin
		fld   = operand[30:23];
		mant  = {8'd0, 1'b1, operand[22:0]};
		if (!fld[0]) begin
			mant = mant << 1;
		end
		// biased result exponent = (fld - 127 - odd)/2 + 127
		ehalf = 8'(({1'b0, fld} + 9'd127 - {8'd0, !fld[0]}) >> 1);
		head           = '0;
		head.valid     = in_valid;
		head.pass      = (operand[30:0] == 31'd0) || operand[31];
		head.word      = (operand[30:0] == 31'd0) ? operand : nan_word_q;
		head.exp       = ehalf;
		head.rem       = mant << 5;
		head.acc       = 32'd0;
		head.bitv      = FIRST_BIT;
		head.done      = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else if (adv) begin
			chain[0] <= head;
		end
	end

	// Row of root cells.
	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		fsqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.din   (chain[g]),
			.dout  (chain[g+1])
		);
	end

	// Final halving, odd rounding rule, carry fix and pack.
	always_comb begin
		last  = chain[STEPS];
		acc_f = last.frac_seen ? last.acc : (last.acc >> 1);
		acc_r = ((acc_f & RND_MASK) == RND_MATCH) ? acc_f + 32'd1 : acc_f;
		r     = acc_r >> 5;
		if (last.pass) begin
			res = last.word;
		end else if (r[24]) begin
			res = {1'b0, last.exp + 8'd1, r[23:1]};
		end else begin
			res = {1'b0, last.exp, r[22:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= last.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			root <= res;
		end
	end

	// A stalled result word must hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(root))
		else $error("root changed while stalled");
	// Input stalls exactly when the output is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("stall mismatch");
	// A valid word at the end of the row reaches the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && chain[STEPS].valid |=> out_valid)
		else $error("result word lost");
endmodule

FILE: verif/tb_top.sv
// Self-checking bench for the single precision square root block.
// Uses fsqrt_pkg and float_square_root_top; root words are predicted in the bench.
`timescale 1ns / 1ps

// Keeps the register copy, predicts root words and checks them in order.
class RootScoreboard;
	logic [31:0] nan_reg;
	logic [31:0] pending_roots[$];
	int unsigned mismatches;
	int unsigned roots_checked;
	int unsigned nan_roots;

	function new();
		nan_reg = fsqrt_pkg::NAN_RESET;
		mismatches = 0;
		roots_checked = 0;
		nan_roots = 0;
	endfunction

	// Restoring bit-wise root of a q4.28 value, then the odd rounding rule.
	function logic [31:0] root_fixed(logic [31:0] rem_in);
		logic [31:0] rem;
		logic [31:0] acc;
		logic [31:0] bitv;
		logic [31:0] trial;
		bit int_hit;
		bit frac_seen;
		rem = rem_in;
		acc = '0;
		bitv = fsqrt_pkg::FIRST_BIT;
		int_hit = 0;
		frac_seen = 0;
		for (int step = 0; step < fsqrt_pkg::STEPS; step++) begin
			trial = acc + bitv;
			if ((acc >> 1) >= fsqrt_pkg::Q_ONE || !int_hit) begin
				if (rem >= trial) begin
					rem = rem - trial;
					acc = (acc >> 1) + bitv;
					int_hit = 1;
				end else begin
					acc = acc >> 1;
				end
				bitv = bitv >> 2;
			end else begin
				if (rem >= trial) begin
					rem = rem - trial;
					acc = acc + (bitv << 1);
				end
				bitv = bitv >> 1;
				rem = rem << 1;
				frac_seen = 1;
			end
			if (rem == 0)
				break;
		end
		if (!frac_seen)
			acc = acc >> 1;
		if ((acc & fsqrt_pkg::RND_MASK) == fsqrt_pkg::RND_MATCH)
			acc = acc + 1;
		return acc;
	endfunction

	// Expected root word of one operand word.
	function logic [31:0] predict_root(logic [31:0] w);
		logic [7:0] field;
		logic [31:0] mant;
		logic [31:0] r;
		int e;
		if (w == 32'h0000_0000 || w == 32'h8000_0000)
			return w;
		if (w[31])
			return nan_reg;
		field = w[30:23];
		mant = {8'd0, 1'b1, w[22:0]};
		e = int'(field) - int'(fsqrt_pkg::EXP_BIAS);
		if (!field[0]) begin
			e = e - 1;
			mant = mant << 1;
		end
		e = e / 2;
		mant = mant << 5;
		r = root_fixed(mant) >> 5;
		if (r[24]) begin
			r = r >> 1;
			e = e + 1;
		end
		r = r & 32'h007F_FFFF;
		return ((32'(e + int'(fsqrt_pkg::EXP_BIAS))) << 23) | r;
	endfunction

	function void note_operand(logic [31:0] w);
		pending_roots.push_back(predict_root(w));
		if (w[31] && w != 32'h8000_0000)
			nan_roots++;
	endfunction

	function void check_root(logic [31:0] got);
		logic [31:0] want;
		if (pending_roots.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected root word %h with nothing pending", got);
			return;
		end
		want = pending_roots.pop_front();
		roots_checked++;
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Root mismatch: expected %h, got %h", want, got);
		end
	endfunction
endclass

module tb_top;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [31:0] operand;
	logic out_valid;
	logic out_stall;
	logic [31:0] root;
	logic cfg_valid;
	logic cfg_ready;
	logic [31:0] cfg_data;

	RootScoreboard sb;
	bit quiet_mode;
	int unsigned stall_left;

	float_square_root_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operand(operand),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.root(root),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Random gap length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (quiet_mode)
			return 0;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Receiver stall pattern, one stretch at a time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			stall_left <= pick_gap();
			out_stall <= 1'b0;
		end
	end

	// Check every root word taken from the block.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_root(root);
	end

	// Drive one operand word and hold it until taken.
	task automatic send_operand(logic [31:0] w);
		int unsigned gap;
		in_valid <= 1'b1;
		operand <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_operand(w);
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_roots.size() != 0)
			@(posedge clk);
	endtask

	// Register write once the pipe is empty.
	task automatic write_nan_word(logic [31:0] v);
		wait_drained();
		repeat (30) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.nan_reg = v;
		cfg_valid <= 1'b0;
	endtask

	// Random operand word: mostly positive values, some negatives and edges.
	function automatic logic [31:0] random_operand();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return $urandom() & 32'h7FFF_FFFF;
		if (roll < 70)
			return {1'b0, 8'($urandom_range(255)), 23'd0};
		if (roll < 80)
			return $urandom() | 32'h8000_0000;
		if (roll < 85)
			return (roll[0]) ? 32'h8000_0000 : 32'h0000_0000;
		return $urandom();
	endfunction

	logic [31:0] edge_words[] = '{
		32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h4080_0000, 32'h4000_0000,
		32'h7F7F_FFFF, 32'h0000_0001, 32'h007F_FFFF, 32'h7F80_0000, 32'h7FC0_0000,
		32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001, 32'hBF80_0000, 32'hFF80_0000,
		32'h0080_0000, 32'h3F80_0001, 32'h4049_0FDB, 32'h0040_0000, 32'h3E80_0000,
		32'h5555_5555, 32'h2AAA_AAAA
	};

	logic [31:0] phase_nan[4];

	initial begin
		sb = new();
		quiet_mode = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operand = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge words first, under the reset value of the register.
		foreach (edge_words[i])
			send_operand(edge_words[i]);

		phase_nan[0] = 32'h0000_0000;
		phase_nan[1] = 32'hFFFF_FFFF;
		phase_nan[2] = $urandom();
		phase_nan[3] = fsqrt_pkg::NAN_RESET;
		for (int phase = 0; phase < 4; phase++) begin
			write_nan_word(phase_nan[phase]);
			quiet_mode = (phase == 1);
			for (int n = 0; n < 470; n++) begin
				send_operand(random_operand());
				// Let the pipe run dry once mid-phase.
				if (phase == 2 && n == 200)
					wait_drained();
			end
		end
		quiet_mode = 0;

		wait_drained();
		repeat (40) @(posedge clk);
		$display("Checked %0d root words over four register settings, %0d of them NaN words.",
			sb.roots_checked, sb.nan_roots);
		if (sb.mismatches == 0 && sb.pending_roots.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Run limit well beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Timeout with %0d root words pending", sb.pending_roots.size());
		$display("CHECK FAILED");
		$finish;
	end
endmodule
